// ===== rtl/core/ray_box_face_hit_test_assert.svh =====
// assertion macros for the ray box face hit test
`ifndef RAY_BOX_FACE_HIT_TEST_ASSERT_SVH
`define RAY_BOX_FACE_HIT_TEST_ASSERT_SVH

// implication checked on the same edge
`define RBFH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication checked on the next edge
`define RBFH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rbfh_pkg.sv =====
// ---------------------------------------------------------------------------
// rbfh_pkg
// shared types and register indexes of the ray box face hit test
// ---------------------------------------------------------------------------
package rbfh_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_TOL    = 3'd6;

  localparam int unsigned NUM_AXES = 3;

  typedef struct packed {
    logic done;
    logic ok;
  } lane_stat_t;

endpackage

// ===== rtl/core/rbfh_ifs.sv =====
// ---------------------------------------------------------------------------
// rbfh channel interfaces
// ray transaction in, hit transaction out
// ---------------------------------------------------------------------------
interface rbfh_ray_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic signed [COORD_WIDTH-1:0] dir_x;
  logic signed [COORD_WIDTH-1:0] dir_y;
  logic signed [COORD_WIDTH-1:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface rbfh_hit_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic signed [COORD_WIDTH-1:0] hit_distance;

  modport source (output valid, hit, point_x, point_y, point_z, hit_distance,
                  input ready);
  modport sink (input valid, hit, point_x, point_y, point_z, hit_distance,
                output ready);
endinterface

// ===== rtl/core/rbfh_div.sv =====
// ---------------------------------------------------------------------------
// rbfh_div
// radix-2 restoring divider, (num << FRACTION_BITS) / den, saturated
// ---------------------------------------------------------------------------
module rbfh_div #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [COORD_WIDTH:0]   num,
  input  logic signed [COORD_WIDTH-1:0] den,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] quo
);
  localparam int CW  = COORD_WIDTH;
  localparam int N   = CW + 1 + FRACTION_BITS;
  localparam int CNW = $clog2(N + 1);
  localparam logic [CNW-1:0] LAST = CNW'(N - 1);

  logic [N-1:0]    dvd_r;
  logic [CW:0]     rem_r;
  logic [CW-1:0]   ud_r;
  logic            neg_r;
  logic            busy_r;
  logic            done_r;
  logic [CNW-1:0]  cnt_r;

  logic [CW:0]     un;
  logic [CW-1:0]   ud;
  logic [CW:0]     trial;
  logic            ge;
  logic            sat;
  logic [CW-1:0]   qm;

  assign un    = num[CW] ? (CW+1)'(-num) : num;
  assign ud    = den[CW-1] ? CW'(-den) : den;
  assign trial = {rem_r[CW-1:0], dvd_r[N-1]};
  assign ge    = trial >= {1'b0, ud_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {un, {FRACTION_BITS{1'b0}}};
      rem_r <= '0;
      ud_r  <= ud;
      neg_r <= num[CW] ^ den[CW-1];
    end else if (busy_r) begin
      rem_r <= ge ? trial - {1'b0, ud_r} : trial;
      dvd_r <= {dvd_r[N-2:0], ge};
    end
  end

  // quotient at or above 2^(CW-1) saturates
  assign sat  = |dvd_r[N-1:CW-1];
  assign qm   = dvd_r[CW-1:0];
  assign done = done_r;

  always_comb begin
    if (neg_r) begin
      quo = sat ? {1'b1, {(CW-1){1'b0}}} : $signed(-qm);
    end else begin
      quo = sat ? {1'b0, {(CW-1){1'b1}}} : $signed(qm);
    end
  end
endmodule

// ===== rtl/core/rbfh_lane.sv =====
// ---------------------------------------------------------------------------
// rbfh_lane
// one axis face: divide for distance, multiply back, check against the box
// ---------------------------------------------------------------------------
module rbfh_lane #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 16,
  parameter int AXIS          = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [COORD_WIDTH-1:0] org [3],
  input  logic signed [COORD_WIDTH-1:0] dir [3],
  input  logic signed [COORD_WIDTH-1:0] lo [3],
  input  logic signed [COORD_WIDTH-1:0] hi [3],
  input  logic [COORD_WIDTH-2:0]        tol,
  output rbfh_pkg::lane_stat_t          stat,
  output logic signed [COORD_WIDTH-1:0] t_out,
  output logic signed [COORD_WIDTH-1:0] pos_out [3]
);
  import rbfh_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int PW = 2 * CW - F + 1;

  logic signed [CW-1:0]   plane;
  logic signed [CW:0]     num;
  logic                   div_done;
  logic signed [CW-1:0]   quo;

  logic signed [CW-1:0]   t_r;
  logic                   mul_v_r;
  logic                   chk_v_r;
  logic signed [2*CW-1:0] prod_r [3];
  logic                   done_r;
  logic                   ok_r;
  logic signed [CW-1:0]   pos_r [3];

  logic signed [PW-1:0]   pos [3];
  logic signed [CW:0]     lo_t [3];
  logic signed [CW:0]     hi_t [3];
  logic [2:0]             in_box;
  logic signed [CW-1:0]   pos_sat [3];

  assign plane = (dir[AXIS] > 0) ? lo[AXIS] : hi[AXIS];
  assign num   = $signed({plane[CW-1], plane}) - $signed({org[AXIS][CW-1], org[AXIS]});

  rbfh_div #(
    .COORD_WIDTH   (CW),
    .FRACTION_BITS (F)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .num   (num),
    .den   (dir[AXIS]),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pos[j] = $signed({{(CW-F+1){org[j][CW-1]}}, org[j]})
             + $signed({prod_r[j][2*CW-1], prod_r[j][2*CW-1:F]});
      lo_t[j] = $signed({lo[j][CW-1], lo[j]}) - $signed({2'b00, tol});
      hi_t[j] = $signed({hi[j][CW-1], hi[j]}) + $signed({2'b00, tol});
      in_box[j] = (pos[j] >= $signed({{(CW-F){lo_t[j][CW]}}, lo_t[j]})) &&
                  (pos[j] <= $signed({{(CW-F){hi_t[j][CW]}}, hi_t[j]}));
      if (pos[j][PW-1:CW-1] == {(PW-CW+1){pos[j][PW-1]}}) begin
        pos_sat[j] = pos[j][CW-1:0];
      end else begin
        pos_sat[j] = pos[j][PW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
      chk_v_r <= 1'b0;
      done_r  <= 1'b0;
      ok_r    <= 1'b0;
    end else begin
      mul_v_r <= div_done;
      chk_v_r <= mul_v_r;
      done_r  <= chk_v_r;
      if (chk_v_r) begin
        ok_r <= (dir[AXIS] != '0) && (&in_box);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      t_r <= quo;
    end
    if (chk_v_r) begin
      for (int j = 0; j < 3; j++) begin
        pos_r[j] <= pos_sat[j];
      end
    end
    for (int j = 0; j < 3; j++) begin
      prod_r[j] <= dir[j] * t_r;
    end
  end

  assign stat.done = done_r;
  assign stat.ok   = ok_r;
  assign t_out     = t_r;
  assign pos_out   = pos_r;
endmodule

// ===== rtl/core/ray_box_face_hit_test.sv =====
// ---------------------------------------------------------------------------
// ray_box_face_hit_test
// ray against axis-aligned box faces, nearest accepted face, Q16.16
// ---------------------------------------------------------------------------
// A ray transaction (origin, direction in the box frame) enters on in_ray and
// one hit transaction leaves on out_hit for each ray. The box corners and
// the edge tolerance are written through cfg_we / cfg_index / cfg_data.
// Three axis lanes run side by side, each with its own bit-serial divider.
// A new ray is taken only once the previous one has left the lanes and its
// result has been committed, so the lanes hold one ray at a time. A ray may
// be accepted while the last hit transaction still waits on out_hit; its
// result is committed only after that one is taken. On a miss, hit is low
// and the last held point and distance are sent again. Reset clears the held
// point and distance to zero and loads the box with min 0, max 1.0 and
// tolerance 0.05.
// ---------------------------------------------------------------------------
module ray_box_face_hit_test #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rbfh_ray_if.sink                          in_ray,
  rbfh_hit_if.source                        out_hit,
  input  logic                              cfg_we,
  input  logic [rbfh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [COORD_WIDTH-1:0]            cfg_data
);
  import rbfh_pkg::*;

  `include "ray_box_face_hit_test_assert.svh"

  localparam int CW = COORD_WIDTH;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]           state_r;
  logic                 start_r;
  logic                 out_valid_r;
  logic                 hit_r;
  logic signed [CW-1:0] org_r [3];
  logic signed [CW-1:0] dir_r [3];
  logic signed [CW-1:0] lo_r [3];
  logic signed [CW-1:0] hi_r [3];
  logic [CW-2:0]        tol_r;
  logic signed [CW-1:0] held_pos_r [3];
  logic signed [CW-1:0] held_t_r;

  lane_stat_t           stat [3];
  logic signed [CW-1:0] lane_t [3];
  logic signed [CW-1:0] lane_pos [3][3];

  logic                 accept;
  logic                 commit;
  logic                 best_hit;
  logic [1:0]           best_ax;
  logic signed [CW-1:0] best_t;

  assign accept = in_ray.valid && in_ray.ready;
  assign in_ray.ready = (state_r == ST_IDLE);
  assign commit = (state_r == ST_HOLD) && (!out_valid_r || out_hit.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= accept;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_hit.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: if (accept) state_r <= ST_BUSY;
        ST_BUSY: if (stat[0].done) state_r <= ST_HOLD;
        ST_HOLD: if (commit) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      org_r[0] <= in_ray.origin_x;
      org_r[1] <= in_ray.origin_y;
      org_r[2] <= in_ray.origin_z;
      dir_r[0] <= in_ray.dir_x;
      dir_r[1] <= in_ray.dir_y;
      dir_r[2] <= in_ray.dir_z;
    end
  end

  // configuration and held result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 3; j++) begin
        lo_r[j]       <= '0;
        hi_r[j]       <= CW'(1) << FRACTION_BITS;
        held_pos_r[j] <= '0;
      end
      tol_r    <= (CW-1)'(3277);
      held_t_r <= '0;
      hit_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BOX_MIN_X: lo_r[0] <= cfg_data;
          REG_BOX_MIN_Y: lo_r[1] <= cfg_data;
          REG_BOX_MIN_Z: lo_r[2] <= cfg_data;
          REG_BOX_MAX_X: hi_r[0] <= cfg_data;
          REG_BOX_MAX_Y: hi_r[1] <= cfg_data;
          REG_BOX_MAX_Z: hi_r[2] <= cfg_data;
          REG_EDGE_TOL:  tol_r   <= cfg_data[CW-2:0];
          default: ;
        endcase
      end
      if (commit) begin
        hit_r <= best_hit;
        if (best_hit) begin
          held_pos_r <= lane_pos[best_ax];
          held_t_r   <= best_t;
        end
      end
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    rbfh_lane #(
      .COORD_WIDTH   (CW),
      .FRACTION_BITS (FRACTION_BITS),
      .AXIS          (a)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (start_r),
      .org     (org_r),
      .dir     (dir_r),
      .lo      (lo_r),
      .hi      (hi_r),
      .tol     (tol_r),
      .stat    (stat[a]),
      .t_out   (lane_t[a]),
      .pos_out (lane_pos[a])
    );
  end

  // nearest accepted face, later axis wins a tie
  always_comb begin
    best_hit = 1'b0;
    best_ax  = '0;
    best_t   = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (stat[a].ok && (!best_hit || lane_t[a] <= best_t)) begin
        best_hit = 1'b1;
        best_ax  = 2'(a);
        best_t   = lane_t[a];
      end
    end
  end

  assign out_hit.valid        = out_valid_r;
  assign out_hit.hit          = hit_r;
  assign out_hit.point_x      = held_pos_r[0];
  assign out_hit.point_y      = held_pos_r[1];
  assign out_hit.point_z      = held_pos_r[2];
  assign out_hit.hit_distance = held_t_r;

  `RBFH_ASSERT_NXT(a_accept_busy, accept, state_r == ST_BUSY, "ray accepted but lanes not busy")
  `RBFH_ASSERT_IMP(a_lanes_sync, stat[0].done, stat[1].done && stat[2].done, "lanes out of step")
  `RBFH_ASSERT_NXT(a_miss_holds, commit && !best_hit, $stable(held_t_r) && !hit_r, "miss changed held distance")
endmodule

// ===== test/ray_box_face_hit_test_test.sv =====
// ---------------------------------------------------------------------------
// ray_box_face_hit_test_test
// self-checking testbench: directed and random rays against several boxes,
// every hit transaction compared with a predicted one, random bursts and stalls
// ---------------------------------------------------------------------------
module ray_box_face_hit_test_test;
  import rbfh_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int LAT = 80;

  typedef struct packed {
    logic          hit;
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [CW-1:0] pz;
    logic [CW-1:0] t_val;
  } hit_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;

  rbfh_ray_if #(.COORD_WIDTH(CW)) ray_ch ();
  rbfh_hit_if #(.COORD_WIDTH(CW)) hit_ch ();

  ray_box_face_hit_test #(.COORD_WIDTH(CW), .FRACTION_BITS(FB)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ray(ray_ch.sink), .out_hit(hit_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  longint box_lo [3];
  longint box_hi [3];
  longint tol;
  longint held_p [3];
  longint held_d;
  hit_rec_t pending_hits [$];
  int mismatches = 0;
  int stall_hold = 0;

  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;

  function automatic longint quot_sat(longint num, longint den);
    logic signed [127:0] q;
    q = ($signed({{64{num[63]}}, num}) <<< FB) / $signed({{64{den[63]}}, den});
    if (q > SMAX) return SMAX;
    if (q < SMIN) return SMIN;
    return longint'(q);
  endfunction

  function automatic longint scale_floor(longint a, longint b);
    logic signed [127:0] p;
    p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
    p = p >>> FB;
    if (p > (128'sd1 <<< 62)) return 64'sd1 <<< 62;
    if (p < -(128'sd1 <<< 62)) return -(64'sd1 <<< 62);
    return longint'(p);
  endfunction

  function automatic longint clip(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic hit_rec_t trace_ray(logic [CW-1:0] o [3], logic [CW-1:0] d [3]);
    longint org [3];
    longint dv [3];
    longint best [3];
    longint pos [3];
    longint plane, t, best_t;
    bit found, in_box;
    hit_rec_t r;
    found = 0;
    best_t = 0;
    for (int j = 0; j < 3; j++) begin
      org[j] = longint'($signed(o[j]));
      dv[j] = longint'($signed(d[j]));
      best[j] = 0;
    end
    for (int ax = 0; ax < 3; ax++) begin
      if (dv[ax] == 0) continue;
      plane = dv[ax] > 0 ? box_lo[ax] : box_hi[ax];
      t = quot_sat(plane - org[ax], dv[ax]);
      if (found && t > best_t) continue;
      in_box = 1;
      for (int j = 0; j < 3; j++) begin
        pos[j] = org[j] + scale_floor(dv[j], t);
        if (pos[j] < box_lo[j] - tol || pos[j] > box_hi[j] + tol) in_box = 0;
      end
      if (!in_box) continue;
      best = pos;
      best_t = t;
      found = 1;
    end
    if (found) begin
      for (int j = 0; j < 3; j++) held_p[j] = clip(best[j]);
      held_d = best_t;
    end
    r.hit = found;
    r.px = held_p[0][CW-1:0];
    r.py = held_p[1][CW-1:0];
    r.pz = held_p[2][CW-1:0];
    r.t_val = held_d[CW-1:0];
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < REG_BOX_MAX_X) box_lo[idx] = longint'($signed(val));
    else if (idx < REG_EDGE_TOL) box_hi[idx - REG_BOX_MAX_X] = longint'($signed(val));
    else if (idx == REG_EDGE_TOL) tol = longint'({1'b0, val[CW-2:0]});
  endtask

  task automatic set_box(longint lx, longint ly, longint lz,
                         longint hx, longint hy, longint hz, longint tl);
    wait (pending_hits.size() == 0);
    repeat (LAT) @(posedge clk);
    write_reg(REG_BOX_MIN_X, lx[CW-1:0]);
    write_reg(REG_BOX_MIN_Y, ly[CW-1:0]);
    write_reg(REG_BOX_MIN_Z, lz[CW-1:0]);
    write_reg(REG_BOX_MAX_X, hx[CW-1:0]);
    write_reg(REG_BOX_MAX_Y, hy[CW-1:0]);
    write_reg(REG_BOX_MAX_Z, hz[CW-1:0]);
    write_reg(REG_EDGE_TOL, tl[CW-1:0]);
  endtask

  int burst_left = 0;

  task automatic send_ray(logic [CW-1:0] ox, logic [CW-1:0] oy, logic [CW-1:0] oz,
                          logic [CW-1:0] dx, logic [CW-1:0] dy, logic [CW-1:0] dz);
    logic [CW-1:0] o [3];
    logic [CW-1:0] d [3];
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 60) : 0) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    @(posedge clk);
    o = '{ox, oy, oz};
    d = '{dx, dy, dz};
    ray_ch.valid <= 1'b1;
    ray_ch.origin_x <= ox;
    ray_ch.origin_y <= oy;
    ray_ch.origin_z <= oz;
    ray_ch.dir_x <= dx;
    ray_ch.dir_y <= dy;
    ray_ch.dir_z <= dz;
    do @(posedge clk); while (!ray_ch.ready);
    pending_hits.push_back(trace_ray(o, d));
    ray_ch.valid <= 1'b0;
  endtask

  function automatic logic [CW-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'h0;
      default: return $signed($urandom_range(0, 'h40000)) - 32'sh20000;
    endcase
  endfunction

  // aim at a random point near the box so most rays hit
  task automatic send_aimed();
    logic [CW-1:0] o [3];
    logic [CW-1:0] d [3];
    longint tgt, span;
    for (int j = 0; j < 3; j++) begin
      span = box_hi[j] - box_lo[j];
      if (span < 1) span = 1;
      if (span > 64'd1 << 30) span = 64'd1 << 30;
      tgt = box_lo[j] + longint'($urandom_range(0, 32'(span)));
      o[j] = tgt[CW-1:0] - 32'($signed($urandom_range(0, 'h60000)) - 32'sh30000);
      d[j] = tgt[CW-1:0] - o[j];
      if ($urandom_range(0, 9) == 0) d[j] = '0;
    end
    send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
  endtask

  task automatic test_default_box();
    send_ray(32'hffff8000, 32'h00008000, 32'h00008000, 32'h00010000, 0, 0);
    send_ray(32'h00018000, 32'h00008000, 32'h00008000, 32'hffff0000, 0, 0);
    send_ray(32'h00008000, 32'h00008000, 32'h00008000, 0, 0, 0);
    send_ray(32'h00030000, 32'h00030000, 32'h00030000, 32'h00010000, 0, 0);
    send_ray(32'hffff0000, 32'hffff0000, 32'hffff0000,
             32'h00010000, 32'h00010000, 32'h00010000);
    send_ray(32'h00008000, 32'h00008000, 32'h00008000, 32'h00000001, 0, 0);
    send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
             32'h80000000, 32'h80000000, 32'h80000000);
    send_ray(32'h80000000, 32'h80000000, 32'h80000000,
             32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_ray(32'h00020000, 32'h00008000, 32'h00008000, 32'h00010000, 0, 0);
    send_ray(32'h00010c00, 32'h00008000, 32'h00008000, 32'hffff0000, 0, 32'h00000100);
    send_ray(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h1, 32'hffffffff);
    send_ray(32'h00008000, 32'h00008000, 32'h00008000, 32'h80000000, 32'h7fffffff, 32'h1);
  endtask

  task automatic test_box_shapes();
    set_box(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
            64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
    repeat (6) send_ray(rnd_coord(), rnd_coord(), rnd_coord(),
                        rnd_coord(), rnd_coord(), rnd_coord());
    set_box(64'sd65536, 64'sd65536, 64'sd65536, 0, 0, 0, 0);
    repeat (4) send_ray(rnd_coord(), rnd_coord(), rnd_coord(),
                        rnd_coord(), rnd_coord(), rnd_coord());
  endtask

  task automatic test_random_rays();
    for (int phase = 0; phase < 4; phase++) begin
      set_box(-longint'($urandom_range(0, 'h30000)), -longint'($urandom_range(0, 'h30000)),
              -longint'($urandom_range(0, 'h30000)), longint'($urandom_range(0, 'h30000)),
              longint'($urandom_range(0, 'h30000)), longint'($urandom_range(0, 'h30000)),
              phase == 3 ? 64'sd0 : longint'($urandom_range(0, 'h4000)));
      for (int n = 0; n < 145; n++) begin
        if ($urandom_range(0, 3) == 0)
          send_ray(rnd_coord(), rnd_coord(), rnd_coord(),
                   rnd_coord(), rnd_coord(), rnd_coord());
        else
          send_aimed();
      end
    end
  endtask

  task automatic test_backpressure();
    stall_hold = 600;
    repeat (8) send_aimed();
  endtask

  // receiver stall pattern
  initial begin
    hit_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_hold > 0) begin
        stall_hold--;
        hit_ch.ready <= 1'b0;
      end else begin
        hit_ch.ready <= ($urandom_range(0, 15) < 11);
      end
    end
  end

  // result checker
  initial begin
    hit_rec_t exp_r, got;
    forever begin
      @(posedge clk);
      if (rst_n && hit_ch.valid && hit_ch.ready) begin
        got = '{hit_ch.hit, hit_ch.point_x, hit_ch.point_y, hit_ch.point_z,
                hit_ch.hit_distance};
        if (pending_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected hit transaction %h", got);
        end else begin
          exp_r = pending_hits.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected hit=%b p=%h %h %h t=%h, got hit=%b p=%h %h %h t=%h",
                       exp_r.hit, exp_r.px, exp_r.py, exp_r.pz, exp_r.t_val,
                       got.hit, got.px, got.py, got.pz, got.t_val);
          end
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("** ray_box_face_hit_test: FAILED **");
    $finish;
  end

  initial begin
    ray_ch.valid = 1'b0;
    ray_ch.origin_x = '0;
    ray_ch.origin_y = '0;
    ray_ch.origin_z = '0;
    ray_ch.dir_x = '0;
    ray_ch.dir_y = '0;
    ray_ch.dir_z = '0;
    for (int j = 0; j < 3; j++) begin
      box_lo[j] = 0;
      box_hi[j] = 64'sd65536;
      held_p[j] = 0;
    end
    tol = 3277;
    held_d = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_default_box();
    test_box_shapes();
    test_backpressure();
    test_random_rays();
    wait (pending_hits.size() == 0);
    repeat (LAT) @(posedge clk);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("** ray_box_face_hit_test: PASSED **");
    end else begin
      $display("** ray_box_face_hit_test: FAILED **");
    end
    $finish;
  end
endmodule
